[sv/llex_pkg.sv]
// Shared types and constants for the line token lexer.
package llex_pkg;

	// Line and line count limits.
	localparam int MaxLine  = 4096;
	localparam int MaxLines = 65536;

	// Fixed field widths of the result word.
	localparam int PosW  = 12;
	localparam int LineW = 16;

	// Saturation limits for character position and line index.
	localparam logic [PosW-1:0]  PosCap  = PosW'((MaxLine - 1 > 4095) ? 4095 : MaxLine - 1);
	localparam logic [LineW-1:0] LineCap =
		LineW'((MaxLines - 1 > 65535) ? 65535 : MaxLines - 1);

	// Result queue geometry.
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// Result kinds as seen on the output channel.
	typedef enum logic [2:0] {
		KIdent  = 3'd0,
		KNumber = 3'd1,
		KOper   = 3'd2,
		KParen  = 3'd3,
		KEos    = 3'd4,
		KError  = 3'd5
	} kind_t;

	// One result word.
	typedef struct packed {
		kind_t             kind;
		logic [PosW-1:0]   start;
		logic [PosW-1:0]   len;
		logic [LineW-1:0]  line;
		logic              last;
	} result_t;

	// Results produced by one accepted word, in order.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

[sv/llex_core.sv]
// Character classification and the token state machine of the lexer.
module llex_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                mode,
	input  logic [7:0]          char_code,
	output llex_pkg::push_t     push
);

	typedef enum logic [2:0] {
		MStart  = 3'd0,
		MIdent  = 3'd1,
		MNumber = 3'd2,
		MOper   = 3'd3,
		MDrop   = 3'd4
	} lmode_t;

	typedef enum logic [2:0] {
		CSpace, COper, CParen, CDigit, CLetter, CDot, COther
	} cls_t;

	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChTab    = 8'h09;
	localparam logic [7:0] ChEq     = 8'h3D;
	localparam logic [7:0] ChGt     = 8'h3E;
	localparam logic [7:0] ChLt     = 8'h3C;
	localparam logic [7:0] ChPlus   = 8'h2B;
	localparam logic [7:0] ChMinus  = 8'h2D;
	localparam logic [7:0] ChStar   = 8'h2A;
	localparam logic [7:0] ChSlash  = 8'h2F;
	localparam logic [7:0] ChLPar   = 8'h28;
	localparam logic [7:0] ChRPar   = 8'h29;
	localparam logic [7:0] ChLBrace = 8'h7B;
	localparam logic [7:0] ChRBrace = 8'h7D;
	localparam logic [7:0] ChDot    = 8'h2E;
	localparam logic [7:0] Ch0      = 8'h30;
	localparam logic [7:0] Ch9      = 8'h39;
	localparam logic [7:0] ChLowA   = 8'h61;
	localparam logic [7:0] ChLowZ   = 8'h7A;
	localparam logic [7:0] ChUpA    = 8'h41;
	localparam logic [7:0] ChUpZ    = 8'h5A;

	// Sort a character byte into its class.
	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		if (c == ChSpace || c == ChTab) begin
			r = CSpace;
		end else if (c == ChEq || c == ChGt || c == ChLt || c == ChPlus || c == ChMinus ||
				c == ChStar || c == ChSlash) begin
			r = COper;
		end else if (c == ChLPar || c == ChRPar || c == ChLBrace || c == ChRBrace) begin
			r = CParen;
		end else if (c == ChDot) begin
			r = CDot;
		end else if (c >= Ch0 && c <= Ch9) begin
			r = CDigit;
		end else if ((c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ)) begin
			r = CLetter;
		end else begin
			r = COther;
		end
		return r;
	endfunction

	lmode_t                         mode_q, nxt_mode;
	logic [llex_pkg::PosW-1:0]      tb_q, nxt_tb;
	logic [llex_pkg::PosW-1:0]      cp_q, nxt_cp;
	logic [llex_pkg::LineW-1:0]     line_q, nxt_line;
	logic                           has_q, nxt_has;

	cls_t                           cls;
	logic                           a_v, b_v, rs, cont, ends, has_after;
	llex_pkg::kind_t                a_kind, b_kind;
	logic [llex_pkg::PosW-1:0]      b_start, b_len;
	llex_pkg::result_t              ra, rb;

	// Next state and the up to two results of the current word.
	always_comb begin
		cls       = classify(char_code);
		nxt_mode  = mode_q;
		nxt_tb    = tb_q;
		nxt_cp    = cp_q;
		nxt_line  = line_q;
		nxt_has   = has_q;
		a_v       = 1'b0;
		b_v       = 1'b0;
		rs        = 1'b0;
		cont      = 1'b0;
		ends      = 1'b0;
		has_after = has_q;
		b_kind    = llex_pkg::KError;
		b_start   = cp_q;
		b_len     = '0;
		unique case (mode_q)
			MIdent:  a_kind = llex_pkg::KIdent;
			MNumber: a_kind = llex_pkg::KNumber;
			default: a_kind = llex_pkg::KOper;
		endcase

		if (mode) begin
			// End of line: flush a token, then close the sentence.
			if (mode_q == MIdent || mode_q == MNumber || mode_q == MOper) begin
				a_v       = 1'b1;
				has_after = 1'b1;
			end
			if (mode_q != MDrop && has_after) begin
				b_v     = 1'b1;
				b_kind  = llex_pkg::KEos;
				b_start = '0;
			end
			nxt_mode = MStart;
			nxt_tb   = '0;
			nxt_cp   = '0;
			nxt_has  = 1'b0;
			if (line_q < llex_pkg::LineCap) begin
				nxt_line = line_q + 1'b1;
			end
		end else begin
			// Decide whether the character extends, ends or breaks the token.
			unique case (mode_q)
				MStart: begin
					rs = 1'b1;
				end
				MIdent: begin
					cont = (cls == CLetter || cls == CDigit);
					ends = (cls == CDot || cls == CSpace || cls == CParen || cls == COper);
				end
				MNumber: begin
					cont = (cls == CDigit || cls == CDot);
					ends = (cls == CSpace || cls == CParen || cls == CLetter || cls == COper);
				end
				MOper: begin
					cont = (cls == COper);
					ends = (cls == CSpace || cls == CParen || cls == CDigit || cls == CLetter);
				end
				default: begin
				end
			endcase
			if (mode_q == MIdent || mode_q == MNumber || mode_q == MOper) begin
				if (ends) begin
					a_v     = 1'b1;
					nxt_has = 1'b1;
					rs      = 1'b1;
				end else if (!cont) begin
					b_v      = 1'b1;
					nxt_mode = MDrop;
				end
			end
			// Process the character again from the start state.
			if (rs) begin
				unique case (cls)
					CSpace: nxt_mode = MStart;
					COper: begin
						nxt_mode = MOper;
						nxt_tb   = cp_q;
					end
					CDigit: begin
						nxt_mode = MNumber;
						nxt_tb   = cp_q;
					end
					CLetter: begin
						nxt_mode = MIdent;
						nxt_tb   = cp_q;
					end
					CParen: begin
						b_v      = 1'b1;
						b_kind   = llex_pkg::KParen;
						b_len    = llex_pkg::PosW'(1);
						nxt_has  = 1'b1;
						nxt_mode = MStart;
					end
					default: begin
						b_v      = 1'b1;
						nxt_mode = MDrop;
					end
				endcase
			end
			if (cp_q < llex_pkg::PosCap) begin
				nxt_cp = cp_q + 1'b1;
			end
		end

		ra.kind  = a_kind;
		ra.start = tb_q;
		ra.len   = cp_q - tb_q;
		ra.line  = line_q;
		ra.last  = !b_v;
		rb.kind  = b_kind;
		rb.start = b_start;
		rb.len   = b_len;
		rb.line  = line_q;
		rb.last  = 1'b1;

		// Pack the results in order, first slot first.
		push.n  = take ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
		push.r0 = a_v ? ra : rb;
		push.r1 = rb;
	end

	// Lexer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MStart;
			tb_q   <= '0;
			cp_q   <= '0;
			line_q <= '0;
			has_q  <= 1'b0;
		end else if (take) begin
			mode_q <= nxt_mode;
			tb_q   <= nxt_tb;
			cp_q   <= nxt_cp;
			line_q <= nxt_line;
			has_q  <= nxt_has;
		end
	end

	// An end of line always returns the position to the line start.
	a_eol_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode) |=> (cp_q == '0 && mode_q == MStart))
		else $error("position not cleared after end of line");

	// While dropping a line, characters give no result.
	a_drop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !mode && mode_q == MDrop) |-> (push.n == 2'd0))
		else $error("result produced while dropping a line");

endmodule

[sv/llex_outq.sv]
// Small result queue that takes up to two words a cycle and drains one while out_stall is low.
module llex_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  llex_pkg::push_t     push,
	output logic                room,
	output logic                out_valid,
	input  logic                out_stall,
	output llex_pkg::result_t   out_res
);

	llex_pkg::result_t              mem_q [llex_pkg::QDepth];
	logic [llex_pkg::QPtrW-1:0]     head_q, tail_q, tail_nx;
	logic [llex_pkg::QCntW-1:0]     count_q;
	logic                           pop;

	// Handshake and read side.
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_res   = mem_q[head_q];
	assign room      = (count_q <= llex_pkg::QCntW'(llex_pkg::QDepth - 2));
	assign tail_nx   = tail_q + 1'b1;

	// Storage, written in order at the tail.
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[tail_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[tail_nx] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + llex_pkg::QPtrW'(push.n);
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			count_q <= count_q + llex_pkg::QCntW'(push.n) - llex_pkg::QCntW'(pop);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= llex_pkg::QCntW'(llex_pkg::QDepth))
		else $error("result queue overflow");

	// Words only arrive when two slots are free.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("push into a full result queue");

	a_push_n: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd3)
		else $error("bad push count");

endmodule

[sv/line_token_lexer.sv]
// Top level of the line token lexer: state machine feeding a result queue.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   mode, char_code
//   out      output     out_valid/out_stall token_kind, token_start, token_length,
//                                           line_number, last
//
// Each accepted word updates the lexer state in the same cycle and its results are
// written into the result queue registers, from which they leave in order. One word
// is taken per cycle while the four entry result queue has two free slots; a word
// yielding two results fills two slots while the queue drains one result at a time,
// so the queue drain sets the rate then. in_stall depends only on the queue fill.
// arst_n clears the lexer to the start state, line zero, and empties the queue.
module line_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_kind,
	output logic [11:0] token_start,
	output logic [11:0] token_length,
	output logic [15:0] line_number,
	output logic        last
);

	logic               room, take;
	llex_pkg::push_t    push;
	llex_pkg::result_t  res;

	// Input acceptance.
	assign in_stall = !room;
	assign take     = in_valid && room;

	llex_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.mode      (mode),
		.char_code (char_code),
		.push      (push)
	);

	llex_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	// Output fields.
	assign token_kind   = 3'(res.kind);
	assign token_start  = res.start;
	assign token_length = res.len;
	assign line_number  = res.line;
	assign last         = res.last;

endmodule

[test/tb_line_token_lexer.sv]
// Self-checking testbench for the line token lexer: hand-picked and random lines, scoreboard check.
`timescale 1ns / 100ps

module tb_line_token_lexer;

	// Character classes and lexer states of the scoreboard's own lexer.
	typedef enum logic [2:0] {
		ChSpace, ChOper, ChParen, ChDigit, ChLetter, ChDot, ChOther
	} char_class_t;

	typedef enum logic [2:0] {
		LxStart, LxIdent, LxNumber, LxOper, LxDrop
	} lex_state_t;

	// One pending input word; burst words are sent without a gap before the next one.
	typedef struct {
		logic       mode;
		logic [7:0] code;
		bit         burst;
	} word_t;

	localparam logic ModeChar = 1'b0;
	localparam logic ModeEol  = 1'b1;

	localparam logic [7:0] ChLowA = "a";
	localparam logic [7:0] ChUpA  = "A";
	localparam logic [7:0] ChZero = "0";
	localparam logic [7:0] ChTab  = 8'h09;
	localparam logic [7:0] ChBlank = " ";

	localparam int HoldCycles = 400;
	localparam int HoldAfter  = 80;
	localparam int RandWords  = 470;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic [7:0]  char_code = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  token_kind;
	logic [11:0] token_start;
	logic [11:0] token_length;
	logic [15:0] line_number;
	logic        last;

	line_token_lexer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.line_number  (line_number),
		.last         (last)
	);

	always #5 clk = ~clk;

	// Stimulus and scoreboard storage.
	word_t             word_q[$];
	word_t             next_word;
	llex_pkg::result_t token_q[$];

	// Scoreboard copy of the lexer state.
	lex_state_t    lx_state = LxStart;
	logic [11:0]   tok_begin = '0;
	logic [11:0]   col = '0;
	logic [15:0]   line_idx = '0;
	logic          line_tokens = 1'b0;
	int            step_results;

	// Run bookkeeping.
	int words_in = 0;
	int results_seen = 0;
	int in_stall_cycles = 0;
	int faults = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;
	bit calm = 1'b0;

	string op_chars = "=><+-*/";
	string paren_chars = "(){}";

	// Class of one raw byte.
	function automatic char_class_t class_of(input logic [7:0] c);
		if (c == ChBlank || c == ChTab)
			return ChSpace;
		if (c == "=" || c == ">" || c == "<" || c == "+" || c == "-" || c == "*" || c == "/")
			return ChOper;
		if (c == "(" || c == ")" || c == "{" || c == "}")
			return ChParen;
		if (c == ".")
			return ChDot;
		if (c >= "0" && c <= "9")
			return ChDigit;
		if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
			return ChLetter;
		return ChOther;
	endfunction

	function automatic llex_pkg::kind_t kind_of(input lex_state_t s);
		case (s)
			LxIdent:  return llex_pkg::KIdent;
			LxNumber: return llex_pkg::KNumber;
			default:  return llex_pkg::KOper;
		endcase
	endfunction

	// Queue one expected token for the current line.
	function automatic void emit_token(input llex_pkg::kind_t k, input logic [11:0] s,
			input logic [11:0] n);
		llex_pkg::result_t r;
		r.kind = k;
		r.start = s;
		r.len = n;
		r.line = line_idx;
		r.last = 1'b0;
		token_q = {token_q, r};
		step_results++;
	endfunction

	// A character seen from the start state.
	function automatic void lex_from_start(input char_class_t cl, input logic [11:0] p);
		case (cl)
			ChSpace: lx_state = LxStart;
			ChOper: begin
				lx_state = LxOper;
				tok_begin = p;
			end
			ChDigit: begin
				lx_state = LxNumber;
				tok_begin = p;
			end
			ChLetter: begin
				lx_state = LxIdent;
				tok_begin = p;
			end
			ChParen: begin
				emit_token(llex_pkg::KParen, p, 12'd1);
				line_tokens = 1'b1;
				lx_state = LxStart;
			end
			default: begin
				emit_token(llex_pkg::KError, p, 12'd0);
				lx_state = LxDrop;
			end
		endcase
	endfunction

	// Advance the scoreboard lexer by one accepted word and queue its tokens.
	function automatic void lex_word(input logic m, input logic [7:0] c);
		logic [11:0] p;
		char_class_t cl;
		bit cont;
		bit ends;
		step_results = 0;
		if (m == ModeEol) begin
			if (lx_state inside {LxIdent, LxNumber, LxOper}) begin
				emit_token(kind_of(lx_state), tok_begin, col - tok_begin);
				line_tokens = 1'b1;
			end
			if (lx_state != LxDrop && line_tokens)
				emit_token(llex_pkg::KEos, 12'd0, 12'd0);
			lx_state = LxStart;
			tok_begin = '0;
			col = '0;
			line_tokens = 1'b0;
			if (line_idx < llex_pkg::LineCap)
				line_idx++;
		end else begin
			p = col;
			cl = class_of(c);
			if (lx_state == LxStart) begin
				lex_from_start(cl, p);
			end else if (lx_state != LxDrop) begin
				case (lx_state)
					LxIdent: begin
						cont = cl inside {ChLetter, ChDigit};
						ends = cl inside {ChDot, ChSpace, ChParen, ChOper};
					end
					LxNumber: begin
						cont = cl inside {ChDigit, ChDot};
						ends = cl inside {ChSpace, ChParen, ChLetter, ChOper};
					end
					default: begin
						cont = (cl == ChOper);
						ends = cl inside {ChSpace, ChParen, ChDigit, ChLetter};
					end
				endcase
				if (ends) begin
					emit_token(kind_of(lx_state), tok_begin, p - tok_begin);
					line_tokens = 1'b1;
					lex_from_start(cl, p);
				end else if (!cont) begin
					emit_token(llex_pkg::KError, p, 12'd0);
					lx_state = LxDrop;
				end
			end
			if (col < llex_pkg::PosCap)
				col++;
		end
		if (step_results > 0)
			token_q[token_q.size() - 1].last = 1'b1;
	endfunction

	// Gap length: mostly none or short, now and then long; none during calm stretches.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_word(input logic m, input logic [7:0] c, input bit burst = 1'b0);
		word_t w;
		w.mode = m;
		w.code = c;
		w.burst = burst;
		word_q = {word_q, w};
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_word(ModeChar, s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return ChLowA + 8'($urandom_range(0, 25));
		return ChUpA + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return ChZero + 8'($urandom_range(0, 9));
	endfunction

	// One random line: mostly well-formed tokens, with some noise bytes and empty lines.
	task automatic gen_line();
		int ntok;
		int pick;
		int n;
		if ($urandom_range(0, 19) == 0) begin
			add_word(ModeEol, 8'($urandom_range(0, 255)));
			return;
		end
		ntok = $urandom_range(1, 6);
		for (int t = 0; t < ntok; t++) begin
			n = $urandom_range(0, 3);
			for (int i = 0; i < n && i < 2; i++)
				add_word(ModeChar, $urandom_range(0, 1) ? ChBlank : ChTab);
			pick = $urandom_range(0, 19);
			if (pick < 6) begin
				add_word(ModeChar, rand_letter());
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++)
					add_word(ModeChar, $urandom_range(0, 2) ? rand_letter() : rand_digit());
			end else if (pick < 11) begin
				add_word(ModeChar, rand_digit());
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++)
					add_word(ModeChar, $urandom_range(0, 3) ? rand_digit() : 8'(".") );
			end else if (pick < 15) begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					add_word(ModeChar, op_chars[$urandom_range(0, 6)]);
			end else if (pick < 18) begin
				add_word(ModeChar, paren_chars[$urandom_range(0, 3)]);
			end else begin
				add_word(ModeChar, 8'($urandom_range(0, 255)));
			end
		end
		if ($urandom_range(0, 4) == 0)
			add_word(ModeChar, ChBlank);
		add_word(ModeEol, 8'($urandom_range(0, 255)));
	endtask

	// Driver: offers pending words, predicts each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= 1'b0;
			char_code <= 8'd0;
			tx_wait <= 0;
		end else if (in_valid && in_stall) begin
			in_stall_cycles <= in_stall_cycles + 1;
		end else begin
			if (in_valid) begin
				lex_word(mode, char_code);
				words_in <= words_in + 1;
			end
			if (tx_wait != 0) begin
				in_valid <= 1'b0;
				tx_wait <= tx_wait - 1;
			end else if (word_q.size() != 0) begin
				next_word = word_q.pop_front();
				in_valid <= 1'b1;
				mode <= next_word.mode;
				char_code <= next_word.code;
				tx_wait <= next_word.burst ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off once the stream is running, and calm stretches without gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_done <= 1'b0;
			calm <= 1'b0;
		end else begin
			if (hold_cnt != 0)
				hold_cnt <= hold_cnt - 1;
			else if (!hold_done && words_in >= HoldAfter) begin
				hold_cnt <= HoldCycles;
				hold_done <= 1'b1;
			end
			if ($urandom_range(0, 99) == 0)
				calm <= !calm;
		end
	end

	// Monitor: checks each accepted token against the oldest expected one.
	always @(posedge clk or negedge arst_n) begin
		llex_pkg::result_t want;
		llex_pkg::result_t got;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.kind = llex_pkg::kind_t'(token_kind);
				got.start = token_start;
				got.len = token_length;
				got.line = line_number;
				got.last = last;
				results_seen <= results_seen + 1;
				if (token_q.size() == 0) begin
					if (faults < 10)
						$display("%0t: unexpected token kind=%0d start=%0d len=%0d line=%0d last=%0b",
							$realtime, token_kind, token_start, token_length, line_number, last);
					faults <= faults + 1;
				end else begin
					want = token_q.pop_front();
					if (got !== want) begin
						if (faults < 10)
							$display("%0t: kind/start/len/line/last expected %0d/%0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0d/%0b",
								$realtime, want.kind, want.start, want.len, want.line, want.last,
								token_kind, token_start, token_length, line_number, last);
						faults <= faults + 1;
					end
				end
			end
			if (rx_wait != 0)
				rx_wait <= rx_wait - 1;
			else if ($urandom_range(0, 3) == 0)
				rx_wait <= pick_gap();
			out_stall <= (hold_cnt != 0) || (rx_wait != 0);
		end
	end

	// Run limit.
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		int base;

		// Identifier, operator, number and paren tokens, each ended by the next; a paren right after a number.
		add_text("a9=12.5)");
		add_word(ModeEol, 8'h00);
		// Tab, paren, then a dot inside an operator; the end of line after it says nothing.
		add_word(ModeChar, ChTab);
		add_text("{-.");
		add_word(ModeEol, 8'hff);
		// Identifier ended by a dot: token first, then the error; the rest is dropped.
		add_text("Zb.");
		add_word(ModeChar, 8'h00);
		add_word(ModeEol, 8'h00);
		// Identifier still open at end of line, then an empty line.
		add_text("q");
		add_word(ModeEol, 8'h00);
		add_word(ModeEol, 8'h00);
		// Dot in the start state after a blank.
		add_text(" .");
		add_word(ModeEol, 8'h00);
		// A blank line.
		add_word(ModeChar, ChBlank);
		add_word(ModeEol, 8'h00);
		// Other byte inside a number, and the top byte in the start state.
		add_text("8#");
		add_word(ModeEol, 8'h00);
		add_word(ModeChar, 8'hff);
		add_word(ModeEol, 8'h00);

		// Random lines.
		base = word_q.size();
		while (word_q.size() < base + RandWords)
			gen_line();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (word_q.size() != 0 || in_valid)
			@(posedge clk);
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("Run covered %0d words of hand-picked and random lines, with gaps and stalls.",
			words_in);
		$display("Checked %0d tokens; the input was held off for %0d cycles.",
			results_seen, in_stall_cycles);
		if (faults == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
sv/llex_pkg.sv
sv/llex_core.sv
sv/llex_outq.sv
sv/line_token_lexer.sv
test/tb_line_token_lexer.sv
